[rtl/rvid_pkg.sv]
package rvid_pkg;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;
    localparam logic [4:0]  HALT_RS1  = 5'd10;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    typedef enum logic [5:0] {
        OP_INVALID = 6'd0,
        OP_LUI     = 6'd1,
        OP_AUIPC   = 6'd2,
        OP_JAL     = 6'd3,
        OP_JALR    = 6'd4,
        OP_BEQ     = 6'd5,
        OP_BNE     = 6'd6,
        OP_BLT     = 6'd7,
        OP_BGE     = 6'd8,
        OP_BLTU    = 6'd9,
        OP_BGEU    = 6'd10,
        OP_LB      = 6'd11,
        OP_LH      = 6'd12,
        OP_LW      = 6'd13,
        OP_LBU     = 6'd14,
        OP_LHU     = 6'd15,
        OP_SB      = 6'd16,
        OP_SH      = 6'd17,
        OP_SW      = 6'd18,
        OP_ADDI    = 6'd19,
        OP_SLTI    = 6'd20,
        OP_SLTIU   = 6'd21,
        OP_XORI    = 6'd22,
        OP_ORI     = 6'd23,
        OP_ANDI    = 6'd24,
        OP_SLLI    = 6'd25,
        OP_SRLI    = 6'd26,
        OP_SRAI    = 6'd27,
        OP_ADD     = 6'd28,
        OP_SUB     = 6'd29,
        OP_SLL     = 6'd30,
        OP_SLT     = 6'd31,
        OP_SLTU    = 6'd32,
        OP_XOR     = 6'd33,
        OP_OR      = 6'd34,
        OP_AND     = 6'd35,
        OP_SRL     = 6'd36,
        OP_SRA     = 6'd37
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic               halt;
    } t_dec_result;

endpackage

[rtl/rv32i_instruction_decoder_top.sv]
// RV32I instruction decoder.
// Slave stream: one 32-bit instruction word per beat on i_s_axis_tdata.
// Master stream: one decoded result per beat; o_m_axis_tdata carries op,
// rd, rs1, rs2 and the immediate, o_m_axis_tuser carries the halt flag
// raised for the halt marker word 0x0FF00513.
// Two register stages: an input register holding the word and a result
// register after the decode logic. A beat accepted into the input register
// moves into the result register and is presented on the master side from there.
// Throughput is one beat per cycle while i_m_axis_tready stays high; each stage
// advances when the stage after it is empty or is being emptied in the same cycle.
// When the receiver holds i_m_axis_tready low the result register and
// then the input register fill; o_s_axis_tready drops only once both
// hold a beat, and no beat is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties both stages. The block
// keeps no state between words.
module rv32i_instruction_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] instr_word
    input  logic [rvid_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [5:0] op, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
    // [52:21] immediate, [55:53] zero
    output logic [rvid_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [0] halt
    output logic                               o_m_axis_tuser
);

    logic                  r_in_valid;
    logic [31:0]           r_in_word;
    logic                  r_out_valid;
    rvid_pkg::t_dec_result r_out;
    rvid_pkg::t_dec_result dec;
    logic                  out_adv;
    logic                  in_adv;

    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign in_adv          = r_in_valid && out_adv;
    assign o_s_axis_tready = !r_in_valid || out_adv;

    rvid_decode u_decode (
        .i_word   (r_in_word),
        .o_result (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_word <= i_s_axis_tdata;
        end
        if (in_adv) begin
            r_out <= dec;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.immediate, r_out.src2_reg, r_out.src1_reg,
                              r_out.dest_reg, r_out.op};
    assign o_m_axis_tuser  = r_out.halt;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid && r_out == $past(dec))
        else $error("decoded beat not moved into result register");

    a_halt_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.halt) |->
            (r_out.op == rvid_pkg::OP_INVALID && r_out.src1_reg == rvid_pkg::HALT_RS1
             && r_out.immediate == '0))
        else $error("halt result carries unexpected fields");

    a_shamt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op == rvid_pkg::OP_SLLI || r_out.op == rvid_pkg::OP_SRLI
                         || r_out.op == rvid_pkg::OP_SRAI)) |->
            (r_out.immediate[31:5] == '0))
        else $error("shift immediate wider than shamt");

endmodule

[rtl/rvid_decode.sv]
module rvid_decode (
    input  logic [31:0]          i_word,
    output rvid_pkg::t_dec_result o_result
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] shamt;

    assign opc   = i_word[6:0];
    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign rd    = i_word[11:7];
    assign rs1   = i_word[19:15];
    assign rs2   = i_word[24:20];
    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'd0};
    assign shamt = {27'd0, rs2};

    always_comb begin
        o_result = '0;
        o_result.op = rvid_pkg::OP_INVALID;
        if (i_word == rvid_pkg::HALT_WORD) begin
            o_result.halt     = 1'b1;
            o_result.src1_reg = rvid_pkg::HALT_RS1;
        end else begin
            unique case (opc)
                rvid_pkg::OPC_OP: begin
                    o_result.dest_reg = rd;
                    o_result.src1_reg = rs1;
                    o_result.src2_reg = rs2;
                    if (f7 == rvid_pkg::F7_BASE) begin
                        unique case (f3)
                            3'd0: o_result.op = rvid_pkg::OP_ADD;
                            3'd1: o_result.op = rvid_pkg::OP_SLL;
                            3'd2: o_result.op = rvid_pkg::OP_SLT;
                            3'd3: o_result.op = rvid_pkg::OP_SLTU;
                            3'd4: o_result.op = rvid_pkg::OP_XOR;
                            3'd5: o_result.op = rvid_pkg::OP_SRL;
                            3'd6: o_result.op = rvid_pkg::OP_OR;
                            3'd7: o_result.op = rvid_pkg::OP_AND;
                            default: o_result.op = rvid_pkg::OP_INVALID;
                        endcase
                    end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0) begin
                        o_result.op = rvid_pkg::OP_SUB;
                    end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5) begin
                        o_result.op = rvid_pkg::OP_SRA;
                    end
                end
                rvid_pkg::OPC_OP_IMM: begin
                    o_result.dest_reg  = rd;
                    o_result.src1_reg  = rs1;
                    o_result.immediate = imm_i;
                    unique case (f3)
                        3'd0: o_result.op = rvid_pkg::OP_ADDI;
                        3'd1: begin
                            if (f7 == rvid_pkg::F7_BASE) begin
                                o_result.op        = rvid_pkg::OP_SLLI;
                                o_result.immediate = shamt;
                            end
                        end
                        3'd2: o_result.op = rvid_pkg::OP_SLTI;
                        3'd3: o_result.op = rvid_pkg::OP_SLTIU;
                        3'd4: o_result.op = rvid_pkg::OP_XORI;
                        3'd5: begin
                            if (f7 == rvid_pkg::F7_BASE) begin
                                o_result.op        = rvid_pkg::OP_SRLI;
                                o_result.immediate = shamt;
                            end else if (f7 == rvid_pkg::F7_ALT) begin
                                o_result.op        = rvid_pkg::OP_SRAI;
                                o_result.immediate = shamt;
                            end
                        end
                        3'd6: o_result.op = rvid_pkg::OP_ORI;
                        3'd7: o_result.op = rvid_pkg::OP_ANDI;
                        default: o_result.op = rvid_pkg::OP_INVALID;
                    endcase
                end
                rvid_pkg::OPC_LOAD: begin
                    o_result.dest_reg  = rd;
                    o_result.src1_reg  = rs1;
                    o_result.immediate = imm_i;
                    unique case (f3)
                        3'd0:    o_result.op = rvid_pkg::OP_LB;
                        3'd1:    o_result.op = rvid_pkg::OP_LH;
                        3'd2:    o_result.op = rvid_pkg::OP_LW;
                        3'd4:    o_result.op = rvid_pkg::OP_LBU;
                        3'd5:    o_result.op = rvid_pkg::OP_LHU;
                        default: o_result.op = rvid_pkg::OP_INVALID;
                    endcase
                end
                rvid_pkg::OPC_STORE: begin
                    o_result.src1_reg  = rs1;
                    o_result.src2_reg  = rs2;
                    o_result.immediate = imm_s;
                    unique case (f3)
                        3'd0:    o_result.op = rvid_pkg::OP_SB;
                        3'd1:    o_result.op = rvid_pkg::OP_SH;
                        3'd2:    o_result.op = rvid_pkg::OP_SW;
                        default: o_result.op = rvid_pkg::OP_INVALID;
                    endcase
                end
                rvid_pkg::OPC_BRANCH: begin
                    o_result.src1_reg  = rs1;
                    o_result.src2_reg  = rs2;
                    o_result.immediate = imm_b;
                    unique case (f3)
                        3'd0:    o_result.op = rvid_pkg::OP_BEQ;
                        3'd1:    o_result.op = rvid_pkg::OP_BNE;
                        3'd4:    o_result.op = rvid_pkg::OP_BLT;
                        3'd5:    o_result.op = rvid_pkg::OP_BGE;
                        3'd6:    o_result.op = rvid_pkg::OP_BLTU;
                        3'd7:    o_result.op = rvid_pkg::OP_BGEU;
                        default: o_result.op = rvid_pkg::OP_INVALID;
                    endcase
                end
                rvid_pkg::OPC_JAL: begin
                    o_result.op        = rvid_pkg::OP_JAL;
                    o_result.dest_reg  = rd;
                    o_result.immediate = imm_j;
                end
                rvid_pkg::OPC_JALR: begin
                    o_result.op        = (f3 == 3'd0) ? rvid_pkg::OP_JALR
                                                      : rvid_pkg::OP_INVALID;
                    o_result.dest_reg  = rd;
                    o_result.src1_reg  = rs1;
                    o_result.immediate = imm_i;
                end
                rvid_pkg::OPC_AUIPC: begin
                    o_result.op        = rvid_pkg::OP_AUIPC;
                    o_result.dest_reg  = rd;
                    o_result.immediate = imm_u;
                end
                rvid_pkg::OPC_LUI: begin
                    o_result.op        = rvid_pkg::OP_LUI;
                    o_result.dest_reg  = rd;
                    o_result.immediate = imm_u;
                end
                // SYSTEM and unknown opcodes: everything stays zero
                default: o_result = '0;
            endcase
        end
    end

endmodule

[tb/sv/tb_rv32i_instruction_decoder_top.sv]
module tb_rv32i_instruction_decoder_top;

    import rvid_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned ITEMS_PER_PASS = 350;
    localparam int unsigned DRAIN_CYCLES   = 8;

    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [2:0] F3_ADD     = 3'b000;
    localparam logic [2:0] F3_SLL     = 3'b001;
    localparam logic [2:0] F3_SRL     = 3'b101;

    // op by funct3 within each major opcode
    localparam t_op [0:7] OPS_REG    = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                         OP_XOR, OP_SRL, OP_OR, OP_AND};
    localparam t_op [0:7] OPS_IMM    = '{OP_ADDI, OP_INVALID, OP_SLTI, OP_SLTIU,
                                         OP_XORI, OP_INVALID, OP_ORI, OP_ANDI};
    localparam t_op [0:7] OPS_LOAD   = '{OP_LB, OP_LH, OP_LW, OP_INVALID,
                                         OP_LBU, OP_LHU, OP_INVALID, OP_INVALID};
    localparam t_op [0:7] OPS_STORE  = '{OP_SB, OP_SH, OP_SW, OP_INVALID,
                                         OP_INVALID, OP_INVALID, OP_INVALID, OP_INVALID};
    localparam t_op [0:7] OPS_BRANCH = '{OP_BEQ, OP_BNE, OP_INVALID, OP_INVALID,
                                         OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

    localparam logic [0:9][6:0] OPC_POOL = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
                                             OPC_BRANCH, OPC_LOAD, OPC_STORE,
                                             OPC_OP_IMM, OPC_OP, OPC_SYSTEM};

    typedef struct packed {
        logic [31:0] word;
        logic        lit;
        t_dec_result res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // [31:0] instr_word
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [5:0] op, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
    // [52:21] immediate, [55:53] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;        // [0] halt

    t_dec_result dec_exp_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    rv32i_instruction_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic t_dec_result decode_word(input logic [31:0] w);
        t_dec_result r;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic signed [31:0] imm_i;
        r     = '0;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        if (w == HALT_WORD) begin
            r.halt     = 1'b1;
            r.src1_reg = HALT_RS1;
        end else begin
            case (opc)
                OPC_OP: begin
                    if (f7 == F7_BASE)
                        r.op = OPS_REG[f3];
                    else if (f7 == F7_ALT && f3 == F3_ADD)
                        r.op = OP_SUB;
                    else if (f7 == F7_ALT && f3 == F3_SRL)
                        r.op = OP_SRA;
                    r.dest_reg = w[11:7];
                    r.src1_reg = w[19:15];
                    r.src2_reg = w[24:20];
                end
                OPC_OP_IMM: begin
                    // shifts with a bad funct7 keep the I immediate, op invalid
                    r.immediate = imm_i;
                    if (f3 == F3_SLL) begin
                        if (f7 == F7_BASE) begin
                            r.op        = OP_SLLI;
                            r.immediate = {27'd0, w[24:20]};
                        end
                    end else if (f3 == F3_SRL) begin
                        if (f7 == F7_BASE) begin
                            r.op        = OP_SRLI;
                            r.immediate = {27'd0, w[24:20]};
                        end else if (f7 == F7_ALT) begin
                            r.op        = OP_SRAI;
                            r.immediate = {27'd0, w[24:20]};
                        end
                    end else begin
                        r.op = OPS_IMM[f3];
                    end
                    r.dest_reg = w[11:7];
                    r.src1_reg = w[19:15];
                end
                OPC_LOAD: begin
                    r.op        = OPS_LOAD[f3];
                    r.dest_reg  = w[11:7];
                    r.src1_reg  = w[19:15];
                    r.immediate = imm_i;
                end
                OPC_STORE: begin
                    r.op        = OPS_STORE[f3];
                    r.src1_reg  = w[19:15];
                    r.src2_reg  = w[24:20];
                    r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                end
                OPC_BRANCH: begin
                    r.op        = OPS_BRANCH[f3];
                    r.src1_reg  = w[19:15];
                    r.src2_reg  = w[24:20];
                    r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                OPC_JAL: begin
                    r.op        = OP_JAL;
                    r.dest_reg  = w[11:7];
                    r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                OPC_JALR: begin
                    r.op        = (f3 == F3_ADD) ? OP_JALR : OP_INVALID;
                    r.dest_reg  = w[11:7];
                    r.src1_reg  = w[19:15];
                    r.immediate = imm_i;
                end
                OPC_AUIPC: begin
                    r.op        = OP_AUIPC;
                    r.dest_reg  = w[11:7];
                    r.immediate = {w[31:12], 12'd0};
                end
                OPC_LUI: begin
                    r.op        = OP_LUI;
                    r.dest_reg  = w[11:7];
                    r.immediate = {w[31:12], 12'd0};
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // mostly well-formed words with random fields, some raw noise, a few halts
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int unsigned sel;
        int unsigned f7_sel;
        w   = $urandom;
        sel = $urandom_range(99);
        if (sel < 2) begin
            w = HALT_WORD;
        end else if (sel >= 17) begin
            w[6:0] = OPC_POOL[4'($urandom_range(9))];
            if (w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) begin
                f7_sel = $urandom_range(9);
                if (f7_sel < 5)
                    w[31:25] = F7_BASE;
                else if (f7_sel < 8)
                    w[31:25] = F7_ALT;
            end
        end
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w, input t_dec_result exp_res);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        do @(posedge i_clk); while (!o_s_axis_tready);
        dec_exp_q.push_back(exp_res);
    endtask

    // result side: check accepted beats, then pick ready for the next cycle
    initial begin : rx_side
        t_dec_result e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (dec_exp_q.size() == 0) begin
                    $error("unexpected result beat, tdata %h tuser %b",
                           o_m_axis_tdata, o_m_axis_tuser);
                    mismatch_cnt++;
                end else begin
                    e = dec_exp_q.pop_front();
                    if (o_m_axis_tdata[5:0] !== e.op) begin
                        $error("op: expected %0d, actual %0d", e.op, o_m_axis_tdata[5:0]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[10:6] !== e.dest_reg) begin
                        $error("dest_reg: expected %0d, actual %0d",
                               e.dest_reg, o_m_axis_tdata[10:6]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[15:11] !== e.src1_reg) begin
                        $error("src1_reg: expected %0d, actual %0d",
                               e.src1_reg, o_m_axis_tdata[15:11]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[20:16] !== e.src2_reg) begin
                        $error("src2_reg: expected %0d, actual %0d",
                               e.src2_reg, o_m_axis_tdata[20:16]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[52:21] !== e.immediate) begin
                        $error("immediate: expected %h, actual %h",
                               e.immediate, o_m_axis_tdata[52:21]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tdata[55:53] !== 3'd0) begin
                        $error("tdata pad: expected 0, actual %b", o_m_axis_tdata[55:53]);
                        mismatch_cnt++;
                    end
                    if (o_m_axis_tuser !== e.halt) begin
                        $error("halt: expected %b, actual %b", e.halt, o_m_axis_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : tx_side
        t_row        dir_rows[$];
        t_dec_result e;
        logic [31:0] w;
        dir_rows = '{
            '{32'h0FF0_0513, 1'b1, '{OP_INVALID, 5'd0, HALT_RS1, 5'd0, 32'sd0, 1'b1}},
            '{32'h0000_0000, 1'b1, '0},
            '{32'hFFFF_FFFF, 1'b1, '0},
            '{32'h0000_0073, 1'b1, '0},   // ecall
            '{32'h0010_0073, 1'b1, '0},   // ebreak
            '{32'hFFFF_F0B7, 1'b1, '{OP_LUI, 5'd1, 5'd0, 5'd0, 32'hFFFF_F000, 1'b0}},
            '{32'h0000_0F97, 1'b1, '{OP_AUIPC, 5'd31, 5'd0, 5'd0, 32'sd0, 1'b0}},
            '{32'hFFF0_0F93, 1'b1, '{OP_ADDI, 5'd31, 5'd0, 5'd0, -32'sd1, 1'b0}},
            '{32'h7FFF_8F93, 1'b0, '0},
            '{32'h01F1_1093, 1'b0, '0},   // slli shamt 31
            '{32'h4052_5193, 1'b0, '0},   // srai
            '{32'hFE00_1093, 1'b0, '0},   // shift, bad funct7
            '{32'h0200_5093, 1'b0, '0},
            '{32'h01FF_8FB3, 1'b0, '0},
            '{32'h4031_00B3, 1'b0, '0},   // sub
            '{32'h4073_52B3, 1'b0, '0},   // sra
            '{32'h4000_1033, 1'b0, '0},   // alt funct7, bad funct3
            '{32'hFFFF_F0EF, 1'b0, '0},   // jal -2
            '{32'h8000_80E7, 1'b0, '0},
            '{32'h0000_1067, 1'b0, '0},   // jalr, bad funct3
            '{32'hFE00_0FE3, 1'b0, '0},
            '{32'h01FF_F063, 1'b0, '0},
            '{32'h0000_2063, 1'b0, '0},
            '{32'h8001_0083, 1'b0, '0},
            '{32'h7FF1_5083, 1'b0, '0},
            '{32'h0000_3003, 1'b0, '0},
            '{32'hFFFF_AFA3, 1'b0, '0},
            '{32'h0000_3023, 1'b0, '0},
            '{32'h0FF0_0593, 1'b0, '0}    // one bit off the halt marker
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            e = dir_rows[k].lit ? dir_rows[k].res : decode_word(dir_rows[k].word);
            send_word(dir_rows[k].word, e);
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                w = pick_word();
                send_word(w, decode_word(w));
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (dec_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rvid_pkg.sv
rtl/rvid_decode.sv
rtl/rv32i_instruction_decoder_top.sv
tb/sv/tb_rv32i_instruction_decoder_top.sv
